// ===== sv/tlpm_pkg.sv =====
// Shared types and constants for the two-level page map insert block.
package tlpm_pkg;

  localparam int unsigned POOL_TABLES_DEF   = 8;
  localparam int unsigned DIR_ENTRIES       = 1024;
  localparam int unsigned DIR_IDX_W         = 10;
  localparam int unsigned ENTRIES_PER_TABLE = 1024;
  localparam int unsigned TBL_IDX_W         = 10;
  localparam int unsigned PAGE_W            = 20;
  localparam int unsigned FLAGS_W           = 12;
  localparam int unsigned ENTRY_W           = 32;
  localparam int unsigned IN_DATA_W         = 56;
  localparam int unsigned OUT_DATA_W        = 8;
  localparam int unsigned SLOT_OUT_W        = 3;

  localparam logic [FLAGS_W-1:0] FORCED_FLAGS = 12'h003;
  localparam int unsigned        PRESENT_BIT  = 0;

  typedef enum logic [1:0] {
    ST_MAPPED   = 2'd0,
    ST_ALREADY  = 2'd1,
    ST_NO_TABLE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_DIR,
    S_TBL
  } state_t;

endpackage

// ===== sv/tlpm_ram.sv =====
// Generic synchronous RAM with one shared address port and registered read data.
module tlpm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/tlpm_ctrl.sv =====
// Sequencer for the insert: clearing pass, directory lookup, table check and write back.
module tlpm_ctrl #(
  parameter int unsigned POOL_TABLES = tlpm_pkg::POOL_TABLES_DEF,
  localparam int unsigned SLOT_W = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1,
  localparam int unsigned CNT_W  = $clog2(POOL_TABLES + 1),
  localparam int unsigned POOL_W = SLOT_W + tlpm_pkg::TBL_IDX_W
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tlpm_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tlpm_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                dir_we,
  output logic                                dir_re,
  output logic [tlpm_pkg::DIR_IDX_W-1:0]      dir_addr,
  output logic [SLOT_W:0]                     dir_wdata,
  input  logic [SLOT_W:0]                     dir_rdata,
  output logic                                pool_we,
  output logic                                pool_re,
  output logic [POOL_W-1:0]                   pool_addr,
  output logic [tlpm_pkg::ENTRY_W-1:0]        pool_wdata,
  input  logic [tlpm_pkg::ENTRY_W-1:0]        pool_rdata
);

  localparam int unsigned POOL_DEPTH = POOL_TABLES * tlpm_pkg::ENTRIES_PER_TABLE;

  tlpm_pkg::state_t state_r, state_nxt;

  logic [POOL_W-1:0]                clr_r;
  logic [tlpm_pkg::PAGE_W-1:0]      virt_r;
  logic [tlpm_pkg::PAGE_W-1:0]      phys_r;
  logic [tlpm_pkg::FLAGS_W-1:0]     flags_r;
  logic [CNT_W-1:0]                 used_r;
  logic [SLOT_W-1:0]                slot_r;
  logic                             out_valid_r;
  tlpm_pkg::status_t                out_status_r;
  logic [tlpm_pkg::SLOT_OUT_W-1:0]  out_slot_r;
  logic                             out_new_r;

  logic                             clr_done;
  logic                             can_out;
  logic                             full;
  logic                             dir_present;
  logic [SLOT_W-1:0]                dir_slot;
  logic [SLOT_W-1:0]                new_slot;
  logic [SLOT_W+2:0]                new_slot_ext;
  logic [SLOT_W+2:0]                cur_slot_ext;
  logic [tlpm_pkg::TBL_IDX_W-1:0]   tbl_idx;
  logic [tlpm_pkg::ENTRY_W-1:0]     entry;

  logic                             res_load;
  tlpm_pkg::status_t                res_status;
  logic [tlpm_pkg::SLOT_OUT_W-1:0]  res_slot;
  logic                             res_new;
  logic                             alloc;
  logic                             slot_load;

  assign clr_done     = (clr_r == POOL_W'(POOL_DEPTH - 1));
  assign can_out      = !out_valid_r || out_tready;
  assign full         = (used_r == CNT_W'(POOL_TABLES));
  assign dir_present  = dir_rdata[SLOT_W];
  assign dir_slot     = dir_rdata[SLOT_W-1:0];
  assign new_slot     = used_r[SLOT_W-1:0];
  assign new_slot_ext = {3'b000, new_slot};
  assign cur_slot_ext = {3'b000, slot_r};
  assign tbl_idx      = virt_r[tlpm_pkg::TBL_IDX_W-1:0];
  assign entry        = {phys_r, flags_r | tlpm_pkg::FORCED_FLAGS};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tlpm_pkg::S_CLEAR: begin
        if (clr_done) begin
          state_nxt = tlpm_pkg::S_IDLE;
        end
      end
      tlpm_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = tlpm_pkg::S_DIR;
        end
      end
      tlpm_pkg::S_DIR: begin
        if (dir_present) begin
          state_nxt = tlpm_pkg::S_TBL;
        end else if (can_out) begin
          state_nxt = tlpm_pkg::S_IDLE;
        end
      end
      tlpm_pkg::S_TBL: begin
        if (can_out) begin
          state_nxt = tlpm_pkg::S_IDLE;
        end
      end
      default: state_nxt = tlpm_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    dir_we     = 1'b0;
    dir_re     = 1'b0;
    dir_addr   = virt_r[tlpm_pkg::PAGE_W-1:tlpm_pkg::TBL_IDX_W];
    dir_wdata  = '0;
    pool_we    = 1'b0;
    pool_re    = 1'b0;
    pool_addr  = {slot_r, tbl_idx};
    pool_wdata = entry;
    res_load   = 1'b0;
    res_status = tlpm_pkg::ST_MAPPED;
    res_slot   = '0;
    res_new    = 1'b0;
    alloc      = 1'b0;
    slot_load  = 1'b0;
    case (state_r)
      tlpm_pkg::S_CLEAR: begin
        dir_we     = 1'b1;
        dir_addr   = clr_r[tlpm_pkg::DIR_IDX_W-1:0];
        pool_we    = 1'b1;
        pool_addr  = clr_r;
        pool_wdata = '0;
      end
      tlpm_pkg::S_IDLE: begin
        in_tready = 1'b1;
        dir_re    = in_tvalid;
        dir_addr  = in_tdata[tlpm_pkg::PAGE_W-1:tlpm_pkg::TBL_IDX_W];
      end
      tlpm_pkg::S_DIR: begin
        if (dir_present) begin
          pool_re   = 1'b1;
          pool_addr = {dir_slot, tbl_idx};
          slot_load = 1'b1;
        end else if (can_out) begin
          res_load = 1'b1;
          if (full) begin
            res_status = tlpm_pkg::ST_NO_TABLE;
          end else begin
            alloc     = 1'b1;
            dir_we    = 1'b1;
            dir_wdata = {1'b1, new_slot};
            pool_we   = 1'b1;
            pool_addr = {new_slot, tbl_idx};
            res_slot  = new_slot_ext[tlpm_pkg::SLOT_OUT_W-1:0];
            res_new   = 1'b1;
          end
        end
      end
      tlpm_pkg::S_TBL: begin
        if (can_out) begin
          res_load = 1'b1;
          res_slot = cur_slot_ext[tlpm_pkg::SLOT_OUT_W-1:0];
          if (pool_rdata[tlpm_pkg::PRESENT_BIT]) begin
            res_status = tlpm_pkg::ST_ALREADY;
          end else begin
            pool_we = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlpm_pkg::S_CLEAR;
      clr_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == tlpm_pkg::S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (alloc) begin
        used_r <= used_r + 1'b1;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      virt_r  <= in_tdata[tlpm_pkg::PAGE_W-1:0];
      phys_r  <= in_tdata[2*tlpm_pkg::PAGE_W-1:tlpm_pkg::PAGE_W];
      flags_r <= in_tdata[2*tlpm_pkg::PAGE_W+tlpm_pkg::FLAGS_W-1:2*tlpm_pkg::PAGE_W];
    end
    if (slot_load) begin
      slot_r <= dir_slot;
    end
    if (res_load) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
      out_new_r    <= res_new;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_new_r, out_slot_r, out_status_r};

endmodule

// ===== sv/two_level_page_map_insert.sv =====
// Top level of the two-level page map insert block: directory RAM, table pool RAM, sequencer.
//
//  Channel  Ports                  Payload (from bit 0 up)
//  -------  ---------------------  ------------------------------------------------
//  input    in_tvalid/in_tready    virt_page[19:0], phys_page[39:20], entry_flags[51:40]
//  output   out_tvalid/out_tready  status[1:0], table_slot[4:2], new_table[5]
//
// An insert is a directory read, then a table entry read when the directory entry is present,
// then the write back.
// After reset a clearing pass writes POOL_TABLES * 1024 pool words (and the directory
// alongside) at one word a cycle, with in_tready low throughout.
// A held result stalls the next result write, not the acceptance of the next transfer.
module two_level_page_map_insert #(
  parameter int unsigned POOL_TABLES = tlpm_pkg::POOL_TABLES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // virt_page, phys_page, entry_flags, zero fill
  input  logic [tlpm_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status, table_slot, new_table, zero fill
  output logic [tlpm_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int unsigned SLOT_W     = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
  localparam int unsigned POOL_W     = SLOT_W + tlpm_pkg::TBL_IDX_W;
  localparam int unsigned POOL_DEPTH = POOL_TABLES * tlpm_pkg::ENTRIES_PER_TABLE;
  localparam int unsigned POOL_AW    = $clog2(POOL_DEPTH);

  logic                               dir_we;
  logic                               dir_re;
  logic [tlpm_pkg::DIR_IDX_W-1:0]     dir_addr;
  logic [SLOT_W:0]                    dir_wdata;
  logic [SLOT_W:0]                    dir_rdata;
  logic                               pool_we;
  logic                               pool_re;
  logic [POOL_W-1:0]                  pool_addr;
  logic [tlpm_pkg::ENTRY_W-1:0]       pool_wdata;
  logic [tlpm_pkg::ENTRY_W-1:0]       pool_rdata;

  tlpm_ram #(
    .WIDTH (SLOT_W + 1),
    .DEPTH (tlpm_pkg::DIR_ENTRIES)
  ) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .re    (dir_re),
    .addr  (dir_addr),
    .wdata (dir_wdata),
    .rdata (dir_rdata)
  );

  tlpm_ram #(
    .WIDTH (tlpm_pkg::ENTRY_W),
    .DEPTH (POOL_DEPTH)
  ) u_pool_ram (
    .clk   (clk),
    .we    (pool_we),
    .re    (pool_re),
    .addr  (pool_addr[POOL_AW-1:0]),
    .wdata (pool_wdata),
    .rdata (pool_rdata)
  );

  tlpm_ctrl #(
    .POOL_TABLES (POOL_TABLES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .dir_we     (dir_we),
    .dir_re     (dir_re),
    .dir_addr   (dir_addr),
    .dir_wdata  (dir_wdata),
    .dir_rdata  (dir_rdata),
    .pool_we    (pool_we),
    .pool_re    (pool_re),
    .pool_addr  (pool_addr),
    .pool_wdata (pool_wdata),
    .pool_rdata (pool_rdata)
  );

`ifndef SYNTHESIS
  a_pool_rw_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(pool_we && pool_re))
    else $error("Pool RAM read and write in the same cycle.");

  a_no_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!dir_we && !pool_we))
    else $error("Memory write while a new transfer can be taken.");

  a_alloc_writes_table: assert property (@(posedge clk) disable iff (!rst_n)
    (dir_we && dir_wdata[SLOT_W]) |-> pool_we)
    else $error("Directory entry set present without a table entry write.");

  a_one_item_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("Second transfer taken while an insert is in progress.");
`endif

endmodule

// ===== tb/two_level_page_map_insert_test.sv =====
// Testbench for the two-level page map insert block: directed and random inserts, checked
// against a local page table model.
`timescale 1ns / 1ps

module two_level_page_map_insert_test;

  localparam int unsigned POOL       = tlpm_pkg::POOL_TABLES_DEF;
  localparam int unsigned STUCK_MAX  = 50000;
  localparam int unsigned HOLD_SPAN  = 300;
  localparam int unsigned MAX_SHOWN  = 10;

  typedef struct packed {
    tlpm_pkg::status_t status;
    logic [2:0]        slot;
    logic              fresh;
  } map_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  // virt_page, phys_page, entry_flags, zero fill
  logic [tlpm_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  // status, table_slot, new_table, zero fill
  logic [tlpm_pkg::OUT_DATA_W-1:0] out_tdata;

  // Page table model.
  logic                          dir_valid [tlpm_pkg::DIR_ENTRIES];
  int unsigned                   dir_table [tlpm_pkg::DIR_ENTRIES];
  logic [tlpm_pkg::ENTRY_W-1:0]  page_words [POOL * tlpm_pkg::ENTRIES_PER_TABLE];
  int unsigned                   tables_taken;

  map_result_t pending_results[$];
  int unsigned mismatches;
  int unsigned stuck_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        rx_hold = 1'b0;
  int unsigned mapped_dirs[$];

  two_level_page_map_insert #(
    .POOL_TABLES(POOL)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic map_result_t map_insert(logic [tlpm_pkg::PAGE_W-1:0] virt,
                                             logic [tlpm_pkg::PAGE_W-1:0] phys,
                                             logic [tlpm_pkg::FLAGS_W-1:0] flags);
    map_result_t                  res;
    int unsigned                  di;
    int unsigned                  ti;
    int unsigned                  slot;
    logic [tlpm_pkg::ENTRY_W-1:0] word;
    di   = virt[19:10];
    ti   = virt[9:0];
    word = {phys, flags | tlpm_pkg::FORCED_FLAGS};
    res.fresh = 1'b0;
    if (!dir_valid[di]) begin
      if (tables_taken >= POOL) begin
        res.status = tlpm_pkg::ST_NO_TABLE;
        res.slot   = '0;
        return res;
      end
      slot = tables_taken;
      dir_valid[di] = 1'b1;
      dir_table[di] = slot;
      tables_taken++;
      page_words[slot * tlpm_pkg::ENTRIES_PER_TABLE + ti] = word;
      res.status = tlpm_pkg::ST_MAPPED;
      res.slot   = slot[2:0];
      res.fresh  = 1'b1;
      return res;
    end
    slot = (dir_table[di] < POOL) ? dir_table[di] : 0;
    if (page_words[slot * tlpm_pkg::ENTRIES_PER_TABLE + ti][tlpm_pkg::PRESENT_BIT]) begin
      res.status = tlpm_pkg::ST_ALREADY;
    end else begin
      page_words[slot * tlpm_pkg::ENTRIES_PER_TABLE + ti] = word;
      res.status = tlpm_pkg::ST_MAPPED;
    end
    res.slot = slot[2:0];
    return res;
  endfunction

  task automatic send_insert(input logic [tlpm_pkg::PAGE_W-1:0] virt,
                             input logic [tlpm_pkg::PAGE_W-1:0] phys,
                             input logic [tlpm_pkg::FLAGS_W-1:0] flags);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(tlpm_pkg::IN_DATA_W - 2 * tlpm_pkg::PAGE_W - tlpm_pkg::FLAGS_W){1'b0}},
                  flags, phys, virt};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(map_insert(virt, phys, flags));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic int unsigned absent_dir();
    int unsigned d;
    d = $urandom_range(0, tlpm_pkg::DIR_ENTRIES - 1);
    while (dir_valid[d]) d = (d + 1) % tlpm_pkg::DIR_ENTRIES;
    return d;
  endfunction

  // Result checker and receiver stall pattern.
  always @(posedge clk) begin
    map_result_t want;
    map_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = tlpm_pkg::status_t'(out_tdata[1:0]);
      got.slot   = out_tdata[4:2];
      got.fresh  = out_tdata[5];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result transfer: status %0d slot %0d new_table %0b",
                   got.status, got.slot, got.fresh);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("result mismatch (status/slot/new_table): expected %0d/%0d/%0b, got %0d/%0d/%0b",
                     want.status, want.slot, want.fresh, got.status, got.slot, got.fresh);
        end
      end
    end
    out_tready <= !rx_hold && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_MAX) begin
      $display("two_level_page_map_insert verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic test_fresh_and_repeat();
    send_insert(20'h00000, 20'h00000, 12'h000);
    send_insert(20'h00000, 20'hFFFFF, 12'hFFF);
    send_insert(20'h003FF, 20'hFFFFF, 12'hFFF);
    send_insert(20'hFFFFF, 20'hFFFFF, 12'h000);
    send_insert(20'hFFFFF, 20'hFFFFF, 12'hAAA);
    send_insert(20'h00400, 20'h00400, 12'h555);
  endtask

  task automatic test_pool_exhaustion();
    int unsigned d;
    while (tables_taken < POOL) begin
      d = absent_dir();
      send_insert({d[9:0], 10'($urandom)}, 20'($urandom), 12'($urandom));
    end
    d = absent_dir();
    send_insert({d[9:0], 10'h000}, 20'h12345, 12'h000);
    d = absent_dir();
    send_insert({d[9:0], 10'h3FF}, 20'hEDCBA, 12'hFFF);
    send_insert(20'h00401, 20'h00401, 12'h0F0);
    send_insert(20'h00401, 20'h00000, 12'h00F);
    for (int i = 0; i < tlpm_pkg::DIR_ENTRIES; i++)
      if (dir_valid[i]) mapped_dirs.push_back(i);
  endtask

  task automatic send_random_insert();
    logic [tlpm_pkg::PAGE_W-1:0]  virt;
    logic [tlpm_pkg::PAGE_W-1:0]  phys;
    logic [tlpm_pkg::FLAGS_W-1:0] flags;
    int unsigned                  d;
    if ($urandom_range(0, 99) < 15) begin
      virt = 20'($urandom);
    end else begin
      d = mapped_dirs[$urandom_range(0, mapped_dirs.size() - 1)];
      virt[19:10] = d[9:0];
      virt[9:0]   = ($urandom_range(0, 1)) ? 10'($urandom_range(0, 31)) : 10'($urandom);
    end
    phys  = ($urandom_range(0, 3) == 0) ? virt : 20'($urandom);
    flags = 12'($urandom);
    send_insert(virt, phys, flags);
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned tx_idle,
                                     input int unsigned rx_idle);
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    repeat (count) send_random_insert();
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rx_hold <= 1'b1;
    fork
      begin
        repeat (HOLD_SPAN) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    repeat (40) send_random_insert();
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < tlpm_pkg::DIR_ENTRIES; i++) begin
      dir_valid[i] = 1'b0;
      dir_table[i] = 0;
    end
    for (int i = 0; i < POOL * tlpm_pkg::ENTRIES_PER_TABLE; i++) page_words[i] = '0;
    tables_taken  = 0;
    mismatches    = 0;
    stuck_cycles  = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fresh_and_repeat();
    test_pool_exhaustion();
    wait_drained();
    test_random_traffic(260, 16, 85);
    test_random_traffic(260, 85, 16);
    test_random_traffic(260, 0, 0);
    test_backpressure();

    repeat (16) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("two_level_page_map_insert verification clean");
    end else begin
      $display("two_level_page_map_insert verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tlpm_pkg.sv
sv/tlpm_ram.sv
sv/tlpm_ctrl.sv
sv/two_level_page_map_insert.sv
tb/two_level_page_map_insert_test.sv
